FILE: design/sopg_pkg.sv
// Package for the slope/offset/power grade: pipeline depth and table builders.
`timescale 1ns / 1ps
package sopg_pkg;

   // Register stages from input transfer to result register in each lane
   localparam int LANE_LATENCY = 10;

   // Configuration register indexes
   localparam logic [1:0] CSR_SLOPE  = 2'd0;
   localparam logic [1:0] CSR_OFFSET = 2'd1;
   localparam logic [1:0] CSR_POWER  = 2'd2;

   // Floor integer square root
   function automatic longint unsigned isqrt64(input longint unsigned a_val);
      longint unsigned a;
      longint unsigned r;
      longint unsigned bitv;
      a = a_val;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > a) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (a >= r + bitv) begin
            a = a - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // log2(1 + i/2^b) in Q.16 by repeated squaring of a Q1.30 mantissa
   function automatic logic [16:0] log_entry(input int i, input int b);
      longint unsigned m;
      logic [16:0] res;
      m = (64'd1 << 30) + (64'(i) << (30 - b));
      res = '0;
      if (i == (1 << b)) begin
         res = 17'd65536;
      end else begin
         for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            res = res << 1;
            if (m >= (64'd1 << 31)) begin
               m = m >> 1;
               res[0] = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // 2^(i/2^b) in Q1.30 as a product of the selected roots 2^(2^-k)
   function automatic logic [31:0] exp_entry(input int i, input int b);
      longint unsigned roots [0:12];
      longint unsigned v;
      for (int k = 0; k <= 12; k++) roots[k] = 0;
      roots[0] = 64'd1 << 31;
      roots[1] = isqrt64(64'd1 << 61);
      for (int k = 2; k <= b; k++) roots[k] = isqrt64(roots[k - 1] << 30);
      v = 64'd1 << 30;
      if (i == (1 << b)) begin
         v = 64'd1 << 31;
      end else begin
         for (int j = 0; j < b; j++) begin
            if (((i >> j) & 1) != 0) v = (v * roots[b - j]) >> 30;
         end
      end
      return v[31:0];
   endfunction

endpackage

FILE: design/sopg_lane.sv
// One color channel: multiply-add, log2, power multiply, exp2 and rounding.
`timescale 1ns / 1ps
module sopg_lane
   import sopg_pkg::*;
#(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [15:0] sample,
   input  logic        [15:0] slope,
   input  logic        [15:0] offset,
   input  logic        [15:0] power,
   output logic        [15:0] graded
);

   localparam int B   = LOG_TABLE_BITS;
   localparam int N   = 1 << B;
   localparam int LRB = 30 - B;
   localparam int ERB = 28 - B;

   // Constant tables
   logic [16:0] log_tab [0:N];
   logic [31:0] exp_tab [0:N];
   for (genvar gi = 0; gi <= N; gi++) begin : g_tab
      localparam logic [16:0] LOG_V = log_entry(gi, B);
      localparam logic [31:0] EXP_V = exp_entry(gi, B);
      assign log_tab[gi] = LOG_V;
      assign exp_tab[gi] = EXP_V;
   end

   logic [15:0] slope_eff;
   logic [15:0] power_eff;
   assign slope_eff = (slope == 16'd0) ? 16'd1 : slope;
   assign power_eff = (power == 16'd0) ? 16'd1 : power;

   // Stage 1: linear term
   logic signed [33:0] sum_ff, sum_in;
   assign sum_in = 34'(sample * $signed({1'b0, slope_eff}))
                 + 34'($signed(offset) * 34'sd8192);

   // Stage 2: leading one
   logic        pos_in;
   logic [5:0]  e_in;
   logic        zero2_ff;
   logic [5:0]  e2_ff;
   logic [32:0] b2_ff;
   assign pos_in = !sum_ff[33] && (sum_ff != '0);
   always_comb begin
      e_in = '0;
      for (int k = 0; k < 33; k++) begin
         if (sum_ff[k]) e_in = 6'(k);
      end
   end

   // Stage 3: normalize to Q1.30 and split the fraction
   logic [30:0]    nrm;
   logic           zero3_ff;
   logic [5:0]     e3_ff;
   logic [B-1:0]   li3_ff;
   logic [LRB-1:0] lr3_ff;
   always_comb begin
      if (e2_ff <= 6'd30) nrm = 31'(b2_ff << (6'd30 - e2_ff));
      else                nrm = 31'(b2_ff >> (e2_ff - 6'd30));
   end

   // Stage 4: log table read
   logic [B:0]     li_cur;
   logic [B:0]     li_next;
   logic           zero4_ff;
   logic [5:0]     e4_ff;
   logic [16:0]    l0_ff;
   logic [16:0]    dl_ff;
   logic [LRB-1:0] lr4_ff;
   assign li_cur  = {1'b0, li3_ff};
   assign li_next = li_cur + 1'b1;

   // Stage 5: interpolate and add the exponent
   logic [16+LRB:0]    lprod;
   logic [16:0]        lf;
   logic signed [7:0]  eoff;
   logic signed [23:0] l_in, l5_ff;
   logic               zero5_ff;
   assign lprod = (16 + LRB + 1)'(dl_ff) * (16 + LRB + 1)'(lr4_ff);
   assign lf    = l0_ff + 17'(lprod >> LRB);
   assign eoff  = $signed({2'b00, e4_ff}) - 8'sd25;
   assign l_in  = $signed({eoff, 16'h0000}) + $signed({7'b0, lf});

   // Stage 6: scale by the power
   logic signed [40:0] t_in, t6_ff;
   logic               zero6_ff;
   assign t_in = 41'(l5_ff) * 41'($signed({1'b0, power_eff}));

   // Stage 7: split the negative exponent
   logic [40:0]    tneg;
   logic [27:0]    g;
   logic [27:0]    h;
   logic           zero7_ff, sat7_ff, gz7_ff;
   logic [11:0]    q7_ff;
   logic [B-1:0]   ei7_ff;
   logic [ERB-1:0] er7_ff;
   assign tneg = -t6_ff;
   assign g    = tneg[27:0];
   assign h    = -g;

   // Stage 8: exp table read
   logic [B:0]     ei_cur;
   logic [B:0]     ei_next;
   logic           zero8_ff, sat8_ff, gz8_ff;
   logic [11:0]    q8_ff;
   logic [31:0]    x0_ff, dx_ff;
   logic [ERB-1:0] er8_ff;
   assign ei_cur  = {1'b0, ei7_ff};
   assign ei_next = ei_cur + 1'b1;

   // Stage 9: interpolate the mantissa
   logic [31+ERB:0] xprod;
   logic [31:0]     v_in, v9_ff;
   logic            zero9_ff, sat9_ff;
   logic [11:0]     q9_ff;
   assign xprod = (32 + ERB)'(dx_ff) * (32 + ERB)'(er8_ff);
   assign v_in  = gz8_ff ? 32'h8000_0000 : x0_ff + 32'(xprod >> ERB);

   // Stage 10: round to Q1.15
   logic [41:0] rnd;
   logic [41:0] shifted;
   logic [15:0] graded_in, graded_ff;
   assign rnd     = {10'b0, v9_ff} + (42'd1 << (6'd15 + {1'b0, q9_ff[4:0]}));
   assign shifted = rnd >> (6'd16 + {1'b0, q9_ff[4:0]});
   always_comb begin
      if (zero9_ff)              graded_in = 16'd0;
      else if (sat9_ff)          graded_in = 16'd32768;
      else if (q9_ff > 12'd24)   graded_in = 16'd0;
      else                       graded_in = shifted[15:0];
   end

   // Advance every stage together
   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff    <= sum_in;
         zero2_ff  <= !pos_in;
         e2_ff     <= e_in;
         b2_ff     <= sum_ff[32:0];
         zero3_ff  <= zero2_ff;
         e3_ff     <= e2_ff;
         li3_ff    <= nrm[29:LRB];
         lr3_ff    <= nrm[LRB-1:0];
         zero4_ff  <= zero3_ff;
         e4_ff     <= e3_ff;
         l0_ff     <= log_tab[li_cur];
         dl_ff     <= log_tab[li_next] - log_tab[li_cur];
         lr4_ff    <= lr3_ff;
         zero5_ff  <= zero4_ff;
         l5_ff     <= l_in;
         zero6_ff  <= zero5_ff;
         t6_ff     <= t_in;
         zero7_ff  <= zero6_ff;
         sat7_ff   <= !t6_ff[40];
         gz7_ff    <= (g == '0);
         q7_ff     <= tneg[39:28];
         ei7_ff    <= h[27:ERB];
         er7_ff    <= h[ERB-1:0];
         zero8_ff  <= zero7_ff;
         sat8_ff   <= sat7_ff;
         gz8_ff    <= gz7_ff;
         q8_ff     <= q7_ff;
         x0_ff     <= exp_tab[ei_cur];
         dx_ff     <= exp_tab[ei_next] - exp_tab[ei_cur];
         er8_ff    <= er7_ff;
         zero9_ff  <= zero8_ff;
         sat9_ff   <= sat8_ff;
         q9_ff     <= q8_ff;
         v9_ff     <= v_in;
         graded_ff <= graded_in;
      end
   end

   assign graded = graded_ff;

endmodule

FILE: design/slope_offset_power_grade.sv
// Top level: configuration registers, three channel lanes and the result stage.
`timescale 1ns / 1ps
// Grades one RGB pixel per clock: each channel computes max(in*slope+offset,0)
// raised to the channel power, saturated to 1.0 in Q1.15. Three identical lanes
// run side by side; a new pixel is taken every cycle that the result side is not
// stalled, since the ten-stage lane pipeline moves as one. Slope, offset and power
// registers (index 0, 1, 2) are written through the csr channel; the user must write
// them only while the block is idle, as the block itself does not enforce this.
module slope_offset_power_grade
   import sopg_pkg::*;
#(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // red_in, green_in, blue_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // red_out, green_out, blue_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [47:0] slope_ff, offset_ff, power_ff;
   logic [LANE_LATENCY-1:0] vld_ff;
   logic advance;

   // Configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff  <= 48'h1000_1000_1000;
         offset_ff <= '0;
         power_ff  <= 48'h1000_1000_1000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SLOPE:  slope_ff  <= csr_data;
            CSR_OFFSET: offset_ff <= csr_data;
            CSR_POWER:  power_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Move the pipeline unless a result is held
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[LANE_LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LANE_LATENCY-2:0], req_tvalid};
      end
   end

   // Channel lanes; their result registers form the merged output
   for (genvar c = 0; c < 3; c++) begin : g_lane
      sopg_lane #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lane (
         .clock  (clock),
         .enable (advance),
         .sample ($signed(req_tdata[16*c +: 16])),
         .slope  (slope_ff[16*c +: 16]),
         .offset (offset_ff[16*c +: 16]),
         .power  (power_ff[16*c +: 16]),
         .graded (rsp_tdata[16*c +: 16])
      );
   end

`ifndef NO_ASSERTIONS
   a_red_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] <= 16'd32768)
      else $error("red result above one");
   a_blue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:32] <= 16'd32768)
      else $error("blue result above one");
   a_accept_tracked: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted pixel not tracked");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule

FILE: bench/tb_slope_offset_power_grade.sv
// Testbench for the slope/offset/power grade: directed and random pixels against a predictor.
`timescale 1ns / 1ps
module tb_slope_offset_power_grade;
   import sopg_pkg::*;

   localparam int TB = 8;
   localparam int TLEN = (1 << TB) + 1;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } pixel_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // red_in, green_in, blue_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // red_out, green_out, blue_out
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [47:0] csr_data;

   slope_offset_power_grade dut (.*);

   // Grade settings mirrored by the predictor
   logic [47:0] slope_q, offset_q, power_q;
   longint unsigned log_lut [0:TLEN-1];
   longint unsigned exp_lut [0:TLEN-1];
   pixel_t graded_q [$];
   int mismatches;
   int idle_cycles;
   bit timed_out;
   bit stall_on;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Lookup tables built independently with integer arithmetic
   function automatic longint unsigned floor_sqrt(input longint unsigned a_in);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 32;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid <= a_in) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   task automatic build_luts();
      longint unsigned root [0:TB];
      longint unsigned m, v;
      longint unsigned acc;
      root[0] = 64'd1 << 31;
      root[1] = floor_sqrt(64'd1 << 61);
      for (int k = 2; k <= TB; k++) root[k] = floor_sqrt(root[k-1] << 30);
      for (int i = 0; i < TLEN - 1; i++) begin
         m = (64'd1 << 30) + (64'(i) << (30 - TB));
         acc = 0;
         for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            acc = acc << 1;
            if (m >= (64'd1 << 31)) begin
               m = m >> 1;
               acc = acc | 1;
            end
         end
         log_lut[i] = acc;
         v = 64'd1 << 30;
         for (int j = 0; j < TB; j++)
            if ((i >> j) & 1) v = (v * root[TB - j]) >> 30;
         exp_lut[i] = v;
      end
      log_lut[TLEN-1] = 65536;
      exp_lut[TLEN-1] = 64'd1 << 31;
   endtask

   // One channel: max(x*slope+offset,0)^power, saturated, Q1.15
   function automatic logic [15:0] grade_channel(input logic signed [15:0] x,
         input logic [15:0] s_f, input logic signed [15:0] o_f, input logic [15:0] p_f);
      longint sum, lg, t, s, p;
      longint unsigned b, nrm, f, idx, rem, lf, u, q, g, h, v;
      int e;
      s = (s_f == 0) ? 1 : longint'(s_f);
      p = (p_f == 0) ? 1 : longint'(p_f);
      sum = longint'(x) * s + longint'(o_f) * 8192;
      if (sum <= 0) return 16'd0;
      b = sum;
      e = 0;
      while (e < 63 && (b >> (e + 1)) != 0) e++;
      nrm = (e <= 30) ? (b << (30 - e)) : (b >> (e - 30));
      f = nrm - (64'd1 << 30);
      idx = f >> (30 - TB);
      rem = f & ((64'd1 << (30 - TB)) - 1);
      lf = log_lut[idx] + (((log_lut[idx+1] - log_lut[idx]) * rem) >> (30 - TB));
      lg = longint'(e - 25) * 65536 + longint'(lf);
      t = lg * p;
      if (t >= 0) return 16'd32768;
      u = -t;
      q = u >> 28;
      g = u & ((64'd1 << 28) - 1);
      if (g == 0) begin
         v = 64'd1 << 31;
      end else begin
         h = (64'd1 << 28) - g;
         idx = h >> (28 - TB);
         rem = h & ((64'd1 << (28 - TB)) - 1);
         v = exp_lut[idx] + (((exp_lut[idx+1] - exp_lut[idx]) * rem) >> (28 - TB));
      end
      if (q > 24) return 16'd0;
      return 16'((v + (64'd1 << (15 + q))) >> (16 + q));
   endfunction

   function automatic pixel_t grade_pixel(input pixel_t px);
      pixel_t r;
      r.red   = grade_channel(px.red,   slope_q[15:0],  offset_q[15:0],  power_q[15:0]);
      r.green = grade_channel(px.green, slope_q[31:16], offset_q[31:16], power_q[31:16]);
      r.blue  = grade_channel(px.blue,  slope_q[47:32], offset_q[47:32], power_q[47:32]);
      return r;
   endfunction

   // Send one pixel and queue its graded value on transfer
   task automatic send_pixel(input pixel_t px);
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      graded_q.push_back(grade_pixel(px));
   endtask

   task automatic pause_random();
      int n;
      n = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
      req_tvalid <= 1'b0;
      while (graded_q.size() != 0) @(posedge clock);
      repeat (LANE_LATENCY + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SLOPE:  slope_q  = val;
         CSR_OFFSET: offset_q = val;
         CSR_POWER:  power_q  = val;
         default: ;
      endcase
   endtask

   task automatic set_grade(input logic [47:0] s, input logic [47:0] o, input logic [47:0] p);
      write_reg(CSR_SLOPE, s);
      write_reg(CSR_OFFSET, o);
      write_reg(CSR_POWER, p);
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(16'sd0 + $urandom_range(0, 16));
         default: return 16'($urandom);
      endcase
   endfunction

   // Extremes of samples at unity grade, then zero and saturating settings
   task automatic test_directed();
      logic [15:0] vals [8] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000,
                               16'hFFFF, 16'h2000, 16'h1000, 16'h5555};
      foreach (vals[i]) send_pixel('{vals[i], vals[(i+1)%8], vals[(i+3)%8]});
      // zero slope and power fields act as one LSB; large negative offset
      set_grade(48'h0, 48'h8000_8000_8000, 48'h0);
      foreach (vals[i]) send_pixel('{vals[i], vals[(i+2)%8], vals[(i+5)%8]});
      // full slope, largest power: results saturate or round to zero
      set_grade(48'hFFFF_FFFF_FFFF, 48'h7FFF_0001_FFFF, 48'hFFFF_FFFF_FFFF);
      foreach (vals[i]) send_pixel('{vals[i], vals[(i+4)%8], vals[(i+6)%8]});
      req_tvalid <= 1'b0;
   endtask

   // Random pixels over several random grade settings
   task automatic test_random();
      for (int phase = 0; phase < 9; phase++) begin
         set_grade({16'($urandom), 16'($urandom), 16'($urandom)},
                   {16'($urandom), 16'($urandom_range(0, 16'hFFFF)), 16'($urandom)},
                   {16'($urandom_range(1, 8192)), 16'($urandom), 16'($urandom_range(0, 4096))});
         for (int i = 0; i < 150; i++) begin
            if (($urandom & 15) == 0) pause_random();
            send_pixel('{rand_sample(), rand_sample(), rand_sample()});
         end
         req_tvalid <= 1'b0;
      end
   endtask

   // Result stall pattern: long open stretches and bursts of random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         stall_on <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
         rsp_tready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
   end

   // Compare each result transfer with the oldest graded pixel
   always @(posedge clock) begin
      pixel_t want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (graded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = graded_q.pop_front();
            if (want.red !== got.red || want.green !== got.green || want.blue !== got.blue) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                           want.red, want.green, want.blue, got.red, got.green, got.blue);
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SLOPE;
      csr_data = '0;
      mismatches = 0;
      idle_cycles = 0;
      timed_out = 1'b0;
      slope_q = 48'h1000_1000_1000;
      offset_q = '0;
      power_q = 48'h1000_1000_1000;
      build_luts();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      while (graded_q.size() != 0) @(posedge clock);
      repeat (LANE_LATENCY + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
